[design/naive_pattern_matcher_core_assert.svh]
// assertion macros for the naive pattern matcher checker
`ifndef NAIVE_PATTERN_MATCHER_CORE_ASSERT_SVH
`define NAIVE_PATTERN_MATCHER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define NPM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define NPM_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/npm_pkg.sv]
// shared types, constants and helpers of the naive pattern matcher
`timescale 1ns / 1ps

package npm_pkg;

    localparam int MAX_PATTERN = 16;
    // bytes carried by the two pattern registers
    localparam int PAT_BYTES   = 16;
    localparam int PIDX_W      = $clog2(PAT_BYTES);
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int CFG_LEN_W   = 5;
    localparam int DATA_W      = 64;
    localparam int NUM_REGS    = 3;
    localparam int REG_IDX_W   = $clog2(NUM_REGS);
    localparam int ADDR_W      = REG_IDX_W + 3;
    localparam int WORD_W      = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WORD_W-1:0] SAT32 = '1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PAT_LOW  = REG_IDX_W'(0),
        REG_PAT_HIGH = REG_IDX_W'(1),
        REG_PAT_LEN  = REG_IDX_W'(2)
    } t_reg_idx;

    typedef struct packed {
        logic [DATA_W-1:0]    pat_low;
        logic [DATA_W-1:0]    pat_high;
        logic [CFG_LEN_W-1:0] pat_len;
    } t_cfg;

    // one classified byte: a match, an end of text, or both
    typedef struct packed {
        logic              has_match;
        logic              is_last;
        logic [WORD_W-1:0] index;
        logic [WORD_W-1:0] count;
    } t_evt;

    // zero counts as one, anything above the window as the window
    function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        if (len == '0) begin
            res = LEN_W'(1);
        end else if (len > CFG_LEN_W'(MAX_PATTERN)) begin
            res = LEN_W'(MAX_PATTERN);
        end else begin
            res = LEN_W'(len);
        end
        return res;
    endfunction

endpackage

[design/naive_pattern_matcher_core.sv]
// top level of the streaming naive pattern matcher
`timescale 1ns / 1ps

// Streaming naive string matcher. Text bytes are pushed one per transaction,
// with end_of_text on the last byte of a text. The front end shifts each byte
// into a 16-byte window and compares the newest pattern_length bytes against
// the pattern in parallel, so it takes one byte every cycle unless full. Bytes that give
// a match or end a text go into a 4-entry queue; the back end turns each entry
// into one or two results (a match result, then the final count result) and
// hands them out through a one-entry output register, one result per cycle while popped.
// A result passes through the queue and then the output register before it reaches the outputs.
// full rises only when the queue holds 4 pending entries, which happens when
// results are not popped or when many bytes end both a match and a text.
// Counters saturate at 0xFFFFFFFF. Registers sit at byte addresses 0, 8, 16
// (pattern bytes 0-7, pattern bytes 8-15, pattern length). The user must write them
// only while the block is idle; the block does not enforce it. No clearing is needed after reset.
module naive_pattern_matcher_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    i_text_char,
    input  logic                          i_end_of_text,
    output logic                          empty,
    input  logic                          pop,
    output logic [npm_pkg::WORD_W-1:0]    o_match_index,
    output logic [npm_pkg::WORD_W-1:0]    o_match_count,
    output logic                          o_is_final,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [npm_pkg::ADDR_W-1:0]    paddr,
    input  logic [npm_pkg::DATA_W-1:0]    pwdata,
    output logic [npm_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    npm_pkg::t_cfg cfg;
    npm_pkg::t_evt front_evt;
    npm_pkg::t_evt head_evt;
    logic          front_wr;
    logic          in_accept;
    logic          q_empty;
    logic          q_deq;
    logic          out_valid;

    assign in_accept = push && !full;
    assign empty     = !out_valid;

    npm_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    npm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (in_accept),
        .i_text_char   (i_text_char),
        .i_end_of_text (i_end_of_text),
        .o_wr          (front_wr),
        .o_evt         (front_evt)
    );

    npm_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (front_wr),
        .i_wr_data (front_evt),
        .i_rd      (q_deq),
        .o_rd_data (head_evt),
        .o_full    (full),
        .o_empty   (q_empty)
    );

    npm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (!q_empty),
        .i_head        (head_evt),
        .o_deq         (q_deq),
        .o_valid       (out_valid),
        .i_pop         (pop),
        .o_match_index (o_match_index),
        .o_match_count (o_match_count),
        .o_is_final    (o_is_final)
    );

endmodule

[design/npm_cfg.sv]
// register block behind the apb port: pattern bytes and pattern length
`timescale 1ns / 1ps

module npm_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [npm_pkg::ADDR_W-1:0]    i_paddr,
    input  logic [npm_pkg::DATA_W-1:0]    i_pwdata,
    output logic [npm_pkg::DATA_W-1:0]    o_prdata,
    output logic                          o_pready,
    output npm_pkg::t_cfg                 o_cfg
);

    logic [npm_pkg::DATA_W-1:0]    r_pat_low;
    logic [npm_pkg::DATA_W-1:0]    r_pat_high;
    logic [npm_pkg::CFG_LEN_W-1:0] r_pat_len;
    npm_pkg::t_reg_idx             reg_idx;
    logic                          wr_en;

    assign reg_idx  = npm_pkg::t_reg_idx'(i_paddr[npm_pkg::ADDR_W-1:3]);
    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= npm_pkg::CFG_LEN_W'(1);
        end else if (wr_en) begin
            unique case (reg_idx)
                npm_pkg::REG_PAT_LOW:  r_pat_low  <= i_pwdata;
                npm_pkg::REG_PAT_HIGH: r_pat_high <= i_pwdata;
                npm_pkg::REG_PAT_LEN:  r_pat_len  <= i_pwdata[npm_pkg::CFG_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            npm_pkg::REG_PAT_LOW:  o_prdata = r_pat_low;
            npm_pkg::REG_PAT_HIGH: o_prdata = r_pat_high;
            npm_pkg::REG_PAT_LEN:  o_prdata = npm_pkg::DATA_W'(r_pat_len);
            default:               o_prdata = '0;
        endcase
    end

    assign o_cfg.pat_low  = r_pat_low;
    assign o_cfg.pat_high = r_pat_high;
    assign o_cfg.pat_len  = r_pat_len;

endmodule

[design/npm_front.sv]
// front end: byte window, parallel pattern compare, position and match counters
`timescale 1ns / 1ps

module npm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  npm_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    input  logic [7:0]           i_text_char,
    input  logic                 i_end_of_text,
    output logic                 o_wr,
    output npm_pkg::t_evt        o_evt
);

    logic [7:0]                           r_window [npm_pkg::MAX_PATTERN];
    logic [7:0]                           n_window [npm_pkg::MAX_PATTERN];
    logic [npm_pkg::LEN_W-1:0]            r_fill;
    logic [npm_pkg::LEN_W-1:0]            n_fill;
    logic [npm_pkg::WORD_W-1:0]           r_pos;
    logic [npm_pkg::WORD_W-1:0]           n_pos;
    logic [npm_pkg::WORD_W-1:0]           r_count;
    logic [npm_pkg::WORD_W-1:0]           n_count;
    logic [npm_pkg::LEN_W-1:0]            len;
    logic [npm_pkg::PAT_BYTES*8-1:0]      pat_all;
    logic [npm_pkg::LEN_W-1:0]            pat_sel [npm_pkg::MAX_PATTERN];
    logic                                 hit;

    assign len     = npm_pkg::eff_len(i_cfg.pat_len);
    assign pat_all = {i_cfg.pat_high, i_cfg.pat_low};

    always_comb begin
        n_window[0] = i_text_char;
        for (int k = 1; k < npm_pkg::MAX_PATTERN; k++) begin
            n_window[k] = r_window[k-1];
        end
    end

    assign n_fill = (r_fill < npm_pkg::LEN_W'(npm_pkg::MAX_PATTERN)) ?
                    r_fill + npm_pkg::LEN_W'(1) : r_fill;
    assign n_pos  = (r_pos != npm_pkg::SAT32) ? r_pos + 1'b1 : r_pos;

    // window entry k lines up with pattern byte len-1-k
    always_comb begin
        hit = (n_fill >= len);
        for (int k = 0; k < npm_pkg::MAX_PATTERN; k++) begin
            pat_sel[k] = len - npm_pkg::LEN_W'(1) - npm_pkg::LEN_W'(k);
            if (npm_pkg::LEN_W'(k) < len &&
                n_window[k] != pat_all[8*npm_pkg::PIDX_W'(pat_sel[k]) +: 8]) begin
                hit = 1'b0;
            end
        end
    end

    assign n_count = (hit && r_count != npm_pkg::SAT32) ? r_count + 1'b1 : r_count;

    assign o_wr            = i_valid && (hit || i_end_of_text);
    assign o_evt.has_match = hit;
    assign o_evt.is_last   = i_end_of_text;
    assign o_evt.index     = r_pos - npm_pkg::WORD_W'(len - npm_pkg::LEN_W'(1));
    assign o_evt.count     = n_count;

    // stale bytes are never compared: the fill count gates the match
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_window <= n_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_pos   <= '0;
            r_count <= '0;
        end else if (i_valid) begin
            if (i_end_of_text) begin
                r_fill  <= '0;
                r_pos   <= '0;
                r_count <= '0;
            end else begin
                r_fill  <= n_fill;
                r_pos   <= n_pos;
                r_count <= n_count;
            end
        end
    end

endmodule

[design/npm_queue.sv]
// small flop queue of classified bytes between front and back end
`timescale 1ns / 1ps

module npm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  npm_pkg::t_evt    i_wr_data,
    input  logic             i_rd,
    output npm_pkg::t_evt    o_rd_data,
    output logic             o_full,
    output logic             o_empty
);

    npm_pkg::t_evt              r_mem [npm_pkg::QUEUE_DEPTH];
    logic [npm_pkg::QPTR_W-1:0] r_wptr;
    logic [npm_pkg::QPTR_W-1:0] r_rptr;
    logic [npm_pkg::QCNT_W-1:0] r_cnt;
    logic                       do_wr;
    logic                       do_rd;

    assign o_full    = (r_cnt == npm_pkg::QCNT_W'(npm_pkg::QUEUE_DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == npm_pkg::QPTR_W'(npm_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : r_wptr + 1'b1;
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == npm_pkg::QPTR_W'(npm_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : r_rptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[design/npm_back.sv]
// back end: expands each queued entry into one or two results in an output register
`timescale 1ns / 1ps

module npm_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_head_valid,
    input  npm_pkg::t_evt               i_head,
    output logic                        o_deq,
    output logic                        o_valid,
    input  logic                        i_pop,
    output logic [npm_pkg::WORD_W-1:0]  o_match_index,
    output logic [npm_pkg::WORD_W-1:0]  o_match_count,
    output logic                        o_is_final
);

    logic                        r_valid;
    logic                        r_phase;
    logic [npm_pkg::WORD_W-1:0]  r_index;
    logic [npm_pkg::WORD_W-1:0]  r_count;
    logic                        r_final;
    logic                        load;
    logic                        emit_match;

    assign load       = i_head_valid && (!r_valid || i_pop);
    // r_phase set: the match of this entry is out, its final result is next
    assign emit_match = i_head.has_match && !r_phase;
    assign o_deq      = load && !(emit_match && i_head.is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= emit_match && i_head.is_last;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_index <= emit_match ? i_head.index : '0;
            r_count <= i_head.count;
            r_final <= !emit_match;
        end
    end

    assign o_valid       = r_valid;
    assign o_match_index = r_index;
    assign o_match_count = r_count;
    assign o_is_final    = r_final;

endmodule

[design/npm_checker.sv]
// port-level checker for the naive pattern matcher, bound to the top level
`timescale 1ns / 1ps
`include "naive_pattern_matcher_core_assert.svh"

module npm_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic                          empty,
    input  logic                          pop,
    input  logic [npm_pkg::WORD_W-1:0]    o_match_index,
    input  logic [npm_pkg::WORD_W-1:0]    o_match_count,
    input  logic                          o_is_final
);

    // a waiting result holds until it is taken
    `NPM_ASSERT_NXT(a_result_hold, i_clk, i_rst_n, !empty && !pop,
        !empty && $stable(o_match_index) && $stable(o_match_count) && $stable(o_is_final),
        "result changed while waiting")

    // the final count result carries no start position
    `NPM_ASSERT_IMP(a_final_index_zero, i_clk, i_rst_n, !empty && o_is_final,
        o_match_index == '0, "final result with nonzero index")

    // a match result always counts itself
    `NPM_ASSERT_IMP(a_match_count_nonzero, i_clk, i_rst_n, !empty && !o_is_final,
        o_match_count != '0, "match result with zero count")

    // the queue only fills up behind an accepted byte
    `NPM_ASSERT_IMP(a_full_after_push, i_clk, i_rst_n, $rose(full),
        $past(push), "full rose without a byte pushed")

endmodule

bind naive_pattern_matcher_core npm_checker u_npm_checker (.*);

[sim/tb_top.sv]
// self-checking testbench for the streaming naive pattern matcher
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
    } t_text_byte;

    typedef struct {
        logic [npm_pkg::WORD_W-1:0] index;
        logic [npm_pkg::WORD_W-1:0] count;
        logic                       is_last;
    } t_hit;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         push = 1'b0;
    logic                         full;
    logic [7:0]                   i_text_char = '0;
    logic                         i_end_of_text = 1'b0;
    logic                         empty;
    logic                         pop = 1'b0;
    logic [npm_pkg::WORD_W-1:0]   o_match_index;
    logic [npm_pkg::WORD_W-1:0]   o_match_count;
    logic                         o_is_final;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [npm_pkg::ADDR_W-1:0]   paddr = '0;
    logic [npm_pkg::DATA_W-1:0]   pwdata = '0;
    logic [npm_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    naive_pattern_matcher_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_text_char   (i_text_char),
        .i_end_of_text (i_end_of_text),
        .empty         (empty),
        .pop           (pop),
        .o_match_index (o_match_index),
        .o_match_count (o_match_count),
        .o_is_final    (o_is_final),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // text bytes waiting to be pushed, and results still to come
    t_text_byte  text_queue[$];
    t_hit        expected_hits[$];

    int          send_idle_pct = 33;
    int          recv_idle_pct = 73;
    int          n_errors = 0;
    int          n_bytes = 0;
    int          n_matches = 0;
    int          n_text_ends = 0;
    int          n_settings = 0;

    // register copies
    logic [63:0]                   pat_lo_m = '0;
    logic [63:0]                   pat_hi_m = '0;
    logic [npm_pkg::CFG_LEN_W-1:0] pat_len_m = npm_pkg::CFG_LEN_W'(1);

    // per-text matcher state
    logic [7:0]                 win[npm_pkg::MAX_PATTERN];
    int                         win_fill = 0;
    logic [npm_pkg::WORD_W-1:0] txt_pos = '0;
    logic [npm_pkg::WORD_W-1:0] hit_cnt = '0;

    initial begin
        foreach (win[k]) win[k] = '0;
    end

    function automatic int used_len(input logic [npm_pkg::CFG_LEN_W-1:0] len);
        int n;
        n = int'(len);
        if (n == 0) n = 1;
        if (n > npm_pkg::MAX_PATTERN) n = npm_pkg::MAX_PATTERN;
        return n;
    endfunction

    function automatic logic [7:0] pat_byte(input int i);
        logic [63:0] word;
        word = (i % 16 < 8) ? pat_lo_m : pat_hi_m;
        return word[(i % 8) * 8 +: 8];
    endfunction

    // shift one byte into the window and queue the results it causes
    task automatic match_text_byte(input logic [7:0] ch, input logic eot);
        int                         len;
        logic [npm_pkg::WORD_W-1:0] pos;
        bit                         same;
        len = used_len(pat_len_m);
        pos = txt_pos;
        for (int k = npm_pkg::MAX_PATTERN - 1; k > 0; k--) win[k] = win[k-1];
        win[0] = ch;
        if (win_fill < npm_pkg::MAX_PATTERN) win_fill++;
        if (txt_pos != npm_pkg::SAT32) txt_pos++;
        same = (win_fill >= len);
        for (int i = 0; i < len; i++) begin
            if (win[len - 1 - i] != pat_byte(i)) same = 1'b0;
        end
        if (same) begin
            if (hit_cnt != npm_pkg::SAT32) hit_cnt++;
            expected_hits.push_back('{pos - npm_pkg::WORD_W'(len - 1), hit_cnt, 1'b0});
        end
        if (eot) begin
            expected_hits.push_back('{'0, hit_cnt, 1'b1});
            foreach (win[k]) win[k] = '0;
            win_fill = 0;
            txt_pos = '0;
            hit_cnt = '0;
        end
    endtask

    // driver: new values at the falling edge
    always @(negedge i_clk) begin
        push <= (text_queue.size() != 0) && ($urandom_range(99) >= send_idle_pct);
        if (text_queue.size() != 0) begin
            i_text_char <= text_queue[0].ch;
            i_end_of_text <= text_queue[0].eot;
        end
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: accepted transactions at the rising edge
    always @(posedge i_clk) begin : monitor
        t_hit want;
        if (i_rst_n && push && !full) begin
            match_text_byte(i_text_char, i_end_of_text);
            void'(text_queue.pop_front());
            n_bytes++;
        end
        if (i_rst_n && pop && !empty) begin
            if (expected_hits.size() == 0) begin
                $error("unexpected result: index %0h count %0h final %0b",
                       o_match_index, o_match_count, o_is_final);
                n_errors++;
            end else begin
                want = expected_hits.pop_front();
                if (o_match_index !== want.index) begin
                    $error("match_index: expected %0h, got %0h", want.index, o_match_index);
                    n_errors++;
                end
                if (o_match_count !== want.count) begin
                    $error("match_count: expected %0h, got %0h", want.count, o_match_count);
                    n_errors++;
                end
                if (o_is_final !== want.is_last) begin
                    $error("is_final: expected %0b, got %0b", want.is_last, o_is_final);
                    n_errors++;
                end
                if (want.is_last) n_text_ends++;
                else n_matches++;
            end
        end
    end

    task automatic write_reg(input npm_pkg::t_reg_idx idx, input logic [63:0] val);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            npm_pkg::REG_PAT_LOW:  pat_lo_m = val;
            npm_pkg::REG_PAT_HIGH: pat_hi_m = val;
            npm_pkg::REG_PAT_LEN:  pat_len_m = val[npm_pkg::CFG_LEN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic write_pattern(input logic [127:0] pat,
                                 input logic [npm_pkg::CFG_LEN_W-1:0] len);
        write_reg(npm_pkg::REG_PAT_LOW, pat[63:0]);
        write_reg(npm_pkg::REG_PAT_HIGH, pat[127:64]);
        write_reg(npm_pkg::REG_PAT_LEN, 64'(len));
        n_settings++;
    endtask

    // all bytes taken and all results seen, then let the pipeline drain
    task automatic wait_idle();
        while (text_queue.size() != 0 || expected_hits.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic add_byte(input logic [7:0] ch, input logic eot);
        text_queue.push_back('{ch, eot});
    endtask

    // 0: random bytes, 1: two-symbol alphabet (lots of overlap), 2: all ones
    function automatic logic [127:0] make_pattern(input int mode);
        logic [127:0] p;
        logic [7:0]   a;
        logic [7:0]   b;
        a = 8'($urandom_range(255));
        b = 8'($urandom_range(255));
        p = {$urandom, $urandom, $urandom, $urandom};
        if (mode == 1) begin
            for (int i = 0; i < 16; i++) p[i*8 +: 8] = $urandom_range(1) ? a : b;
        end else if (mode == 2) begin
            p = '1;
        end
        return p;
    endfunction

    // texts built mostly from whole and partial copies of the pattern
    task automatic add_texts(input int n_items, input bit leave_open);
        logic [7:0] text[$];
        int         total;
        int         tlen;
        int         len;
        int         r;
        total = 0;
        len = used_len(pat_len_m);
        while (total < n_items) begin
            text.delete();
            tlen = ($urandom_range(9) == 0) ? $urandom_range(41, 80) : $urandom_range(1, 24);
            while (text.size() < tlen) begin
                r = $urandom_range(99);
                if (r < 15) begin
                    for (int i = 0; i < len; i++) text.push_back(pat_byte(i));
                end else if (r < 70) begin
                    text.push_back(pat_byte($urandom_range(len - 1)));
                end else begin
                    text.push_back(8'($urandom_range(255)));
                end
            end
            total += text.size();
            foreach (text[i]) begin
                add_byte(text[i], (i == text.size() - 1) && !(leave_open && total >= n_items));
            end
        end
    endtask

    initial begin
        logic [127:0]                  pat;
        logic [npm_pkg::CFG_LEN_W-1:0] len;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: one-byte pattern of zero
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b1);
        add_byte(8'h00, 1'b1);  // match and text end on the same byte
        add_byte(8'h55, 1'b1);  // text end without a match
        n_settings++;
        wait_idle();

        // full-length pattern, then a text shorter than the pattern
        pat = 128'h7F6E5D4C3B2A1908_F7E6D5C4B3A29180;
        write_pattern(pat, npm_pkg::CFG_LEN_W'(npm_pkg::MAX_PATTERN));
        for (int i = 0; i < npm_pkg::MAX_PATTERN; i++) begin
            add_byte(pat[i*8 +: 8], i == npm_pkg::MAX_PATTERN - 1);
        end
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 3) begin
                send_idle_pct = 73;
                recv_idle_pct = 33;
            end else if (ph == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0: begin pat = make_pattern(0); len = npm_pkg::CFG_LEN_W'(1);  end
                1: begin pat = make_pattern(0); len = npm_pkg::CFG_LEN_W'(16); end
                2: begin pat = make_pattern(2); len = npm_pkg::CFG_LEN_W'(0);  end  // zero means one
                3: begin pat = make_pattern(1); len = '1;                       end  // clamped to 16
                4: begin pat = make_pattern(2); len = npm_pkg::CFG_LEN_W'(17); end
                5: begin
                    pat = make_pattern(1);
                    len = npm_pkg::CFG_LEN_W'($urandom_range(1, 16));
                end
                6: begin
                    pat = make_pattern(0);
                    len = npm_pkg::CFG_LEN_W'($urandom_range(2, 8));
                end
                default: begin
                    pat = make_pattern($urandom_range(1));
                    len = npm_pkg::CFG_LEN_W'($urandom_range(1, 16));
                end
            endcase
            write_pattern(pat, len);
            // an open text carries its window into the next setting
            add_texts(85, (ph < 7) && ($urandom_range(1) == 1));
            wait_idle();
        end

        $display("checked %0d matches and %0d text-end counts from %0d text bytes",
                 n_matches, n_text_ends, n_bytes);
        $display("pattern settings used: %0d, lengths 0 to 31 incl. clamped values",
                 n_settings);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", expected_hits.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/npm_pkg.sv
design/npm_cfg.sv
design/npm_front.sv
design/npm_queue.sv
design/npm_back.sv
design/naive_pattern_matcher_core.sv
design/npm_checker.sv
sim/tb_top.sv
